// File: hw/rtl/fpbd_pkg.sv
// Shared types and codes for the fetch packet break decider.
`timescale 1ns / 1ps

package fpbd_pkg;

   // Item operation codes. The reserved code is accepted and changes nothing.
   typedef enum logic [1:0] {
      OP_JUDGE    = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_LOAD     = 2'd2,
      OP_RESERVED = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      DEC_CONTINUE     = 2'd0,
      DEC_BREAK_BEFORE = 2'd1,
      DEC_BREAK_AFTER  = 2'd2
   } decision_type;

   typedef enum logic [2:0] {
      RSN_NONE       = 3'd0,
      RSN_LOAD_STORE = 3'd1,
      RSN_UNIT       = 3'd2,
      RSN_MODEL      = 3'd3,
      RSN_BARRIER    = 3'd4,
      RSN_CF_LIMIT   = 3'd5,
      RSN_WIDTH      = 3'd6
   } reason_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_LOAD_STORE_LIMIT  = 3'd0;
   localparam logic [2:0] CSR_UNIT_CHECK_ENABLE = 3'd1;
   localparam logic [2:0] CSR_CF_BREAK_ENABLE   = 3'd2;
   localparam logic [2:0] CSR_CF_LIMIT          = 3'd3;
   localparam logic [2:0] CSR_ISSUE_WIDTH       = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   // Counter width and its saturation value.
   localparam int COUNT_W = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   typedef struct packed {
      op_code_type  operation;
      logic [4:0]   op_class;
      logic         is_mem;
      logic         is_cf;
      logic         is_barrier;
      logic         model_break;
      logic [3:0]   ops_in_packet;
      logic [3:0]   class_index;
      logic [31:0]  class_mask;
      logic [3:0]   class_limit;
   } req_type;

   typedef struct packed {
      decision_type decision;
      reason_type   reason;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic execute;   // judge or apply the latched item, load the result register
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

// File: hw/rtl/fetch_packet_break_decider.sv
// Top level of the fetch packet break decider.
`timescale 1ns / 1ps

// The block takes one item at a time and answers each with exactly one
// result item. A judge item runs the break rules in fixed order (load/store
// count, functional-unit class room, model break, barrier, control-flow
// count, issue width, plain control-flow break) and the first rule that
// fires gives the decision and reason. A clear item zeroes the per-packet
// counters and all class use counts; a load item writes one unit class
// entry; every non-judge item answers continue with no reason. An item is
// latched in the idle state; in the execute state the controller runs the
// rule chain in the datapath and loads the result register, so the block
// takes no new item until the last one is executed. The next item is taken
// while the previous result still waits in the result register; a stalled
// result only holds the block once a new item is ready to finish. The
// load/store and control-flow counters saturate at 31. The user must write
// the csr configuration only while the block is idle; the block does not check it.
module fetch_packet_break_decider #(
   parameter int NUM_UNIT_CLASSES = 16,
   parameter int NUM_OP_TYPES_P   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fpbd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fpbd_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [fpbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpbd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   // Commands from the controller into the datapath.
   fpbd_pkg::cmd_type cmd;

   // The controller owns the handshakes and sequences each item.
   fpbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the item latch, the class table, the counters,
   // the configuration registers and the result register.
   fpbd_datapath #(
      .NUM_UNIT_CLASSES (NUM_UNIT_CLASSES),
      .NUM_OP_TYPES_P   (NUM_OP_TYPES_P)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hw/rtl/fpbd_ctrl.sv
// Controller state machine for the fetch packet break decider.
`timescale 1ns / 1ps

module fpbd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpbd_pkg::cmd_type cmd
);

   fpbd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpbd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         fpbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = fpbd_pkg::ST_EXEC;
            end
         end
         fpbd_pkg::ST_EXEC: begin
            // The result register must be empty or emptying this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = fpbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpbd_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != fpbd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/fpbd_datapath.sv
// Datapath for the fetch packet break decider: item latch, class table, counters, rules.
`timescale 1ns / 1ps

module fpbd_datapath #(
   parameter int NUM_UNIT_CLASSES = 16,
   parameter int NUM_OP_TYPES_P   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fpbd_pkg::cmd_type                   cmd,
   input  fpbd_pkg::req_type                   req_data,
   input  logic                                csr_wr_en,
   input  logic [fpbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fpbd_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output fpbd_pkg::rsp_type                   rsp_data
);

   localparam int CW = fpbd_pkg::COUNT_W;

   // Configuration registers.
   logic [3:0] ls_limit_ff;
   logic       unit_en_ff;
   logic       cf_en_ff;
   logic [3:0] cf_limit_ff;
   logic [4:0] issue_width_ff;

   fpbd_pkg::req_type item_ff;
   fpbd_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] mem_cnt_ff, mem_cnt_in;
   logic [CW-1:0] cf_cnt_ff, cf_cnt_in;

   logic [NUM_OP_TYPES_P-1:0] mask_ff  [NUM_UNIT_CLASSES];
   logic [3:0]                limit_ff [NUM_UNIT_CLASSES];
   logic [3:0]                used_ff  [NUM_UNIT_CLASSES];
   logic [3:0]                used_in  [NUM_UNIT_CLASSES];

   logic [NUM_OP_TYPES_P-1:0]   op_onehot;
   logic [NUM_UNIT_CLASSES-1:0] hit_sel;
   logic                        hit_found;
   logic [3:0]                  sel_used;
   logic [3:0]                  sel_limit;
   logic                        idx_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         ls_limit_ff    <= 4'd0;
         unit_en_ff     <= 1'b0;
         cf_en_ff       <= 1'b0;
         cf_limit_ff    <= 4'd1;
         issue_width_ff <= 5'd4;
      end else if (csr_wr_en) begin
         case (csr_index)
            fpbd_pkg::CSR_LOAD_STORE_LIMIT:  ls_limit_ff    <= csr_wr_data[3:0];
            fpbd_pkg::CSR_UNIT_CHECK_ENABLE: unit_en_ff     <= csr_wr_data[0];
            fpbd_pkg::CSR_CF_BREAK_ENABLE:   cf_en_ff       <= csr_wr_data[0];
            fpbd_pkg::CSR_CF_LIMIT:          cf_limit_ff    <= csr_wr_data[3:0];
            fpbd_pkg::CSR_ISSUE_WIDTH:       issue_width_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // One-hot decode of the op type; types beyond the table decode to nothing.
   always_comb begin
      for (int j = 0; j < NUM_OP_TYPES_P; j++) begin
         op_onehot[j] = (item_ff.op_class == 5'(j));
      end
   end

   // First class whose mask holds the op type.
   always_comb begin
      hit_sel   = '0;
      hit_found = 1'b0;
      sel_used  = 4'd0;
      sel_limit = 4'd0;
      for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
         if (!hit_found && (|(mask_ff[i] & op_onehot))) begin
            hit_sel[i] = 1'b1;
            hit_found  = 1'b1;
         end
      end
      for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
         sel_used  = sel_used  | (used_ff[i]  & {4{hit_sel[i]}});
         sel_limit = sel_limit | (limit_ff[i] & {4{hit_sel[i]}});
      end
   end

   assign idx_valid = ({1'b0, item_ff.class_index} < 5'(NUM_UNIT_CLASSES));

   // Rule chain and state updates for the latched item.
   always_comb begin
      logic [CW-1:0] mem_next;
      logic [CW-1:0] cf_next;
      logic          done;
      logic [4:0]    ops_plus;

      mem_cnt_in = mem_cnt_ff;
      cf_cnt_in  = cf_cnt_ff;
      for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
         used_in[i] = used_ff[i];
      end
      rsp_in.decision = fpbd_pkg::DEC_CONTINUE;
      rsp_in.reason   = fpbd_pkg::RSN_NONE;
      done            = 1'b0;

      mem_next = (mem_cnt_ff == fpbd_pkg::COUNT_MAX) ? fpbd_pkg::COUNT_MAX
               : mem_cnt_ff + CW'(item_ff.is_mem);
      cf_next  = (cf_cnt_ff == fpbd_pkg::COUNT_MAX) ? fpbd_pkg::COUNT_MAX
               : cf_cnt_ff + CW'(item_ff.is_cf);
      ops_plus = {1'b0, item_ff.ops_in_packet} + 5'd1;

      case (item_ff.operation)
         fpbd_pkg::OP_JUDGE: begin
            if (ls_limit_ff != 4'd0) begin
               mem_cnt_in = mem_next;
               if (mem_next > {1'b0, ls_limit_ff}) begin
                  rsp_in.decision = fpbd_pkg::DEC_BREAK_BEFORE;
                  rsp_in.reason   = fpbd_pkg::RSN_LOAD_STORE;
                  done            = 1'b1;
               end
            end
            if (!done && unit_en_ff && hit_found) begin
               if (sel_used < sel_limit) begin
                  for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
                     if (hit_sel[i]) begin
                        used_in[i] = used_ff[i] + 4'd1;
                     end
                  end
               end else begin
                  rsp_in.decision = fpbd_pkg::DEC_BREAK_BEFORE;
                  rsp_in.reason   = fpbd_pkg::RSN_UNIT;
                  done            = 1'b1;
               end
            end
            if (!done && item_ff.model_break) begin
               rsp_in.decision = fpbd_pkg::DEC_BREAK_BEFORE;
               rsp_in.reason   = fpbd_pkg::RSN_MODEL;
               done            = 1'b1;
            end
            if (!done && item_ff.is_barrier) begin
               rsp_in.decision = fpbd_pkg::DEC_BREAK_AFTER;
               rsp_in.reason   = fpbd_pkg::RSN_BARRIER;
               done            = 1'b1;
            end
            if (!done && cf_en_ff) begin
               cf_cnt_in = cf_next;
               if (cf_next == {1'b0, cf_limit_ff}) begin
                  rsp_in.decision = fpbd_pkg::DEC_BREAK_AFTER;
                  rsp_in.reason   = fpbd_pkg::RSN_CF_LIMIT;
                  done            = 1'b1;
               end
            end
            if (!done && (ops_plus == issue_width_ff)) begin
               rsp_in.decision = fpbd_pkg::DEC_BREAK_AFTER;
               rsp_in.reason   = fpbd_pkg::RSN_WIDTH;
               done            = 1'b1;
            end
            if (!done && cf_en_ff && item_ff.is_cf) begin
               rsp_in.decision = fpbd_pkg::DEC_BREAK_AFTER;
               rsp_in.reason   = fpbd_pkg::RSN_NONE;
            end
         end
         fpbd_pkg::OP_CLEAR: begin
            mem_cnt_in = '0;
            cf_cnt_in  = '0;
            for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
               used_in[i] = 4'd0;
            end
         end
         fpbd_pkg::OP_LOAD: begin
            for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
               if (idx_valid && (item_ff.class_index == 4'(i))) begin
                  used_in[i] = 4'd0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_cnt_ff <= '0;
         cf_cnt_ff  <= '0;
         for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
            mask_ff[i]  <= '0;
            limit_ff[i] <= 4'd0;
            used_ff[i]  <= 4'd0;
         end
      end else if (cmd.execute) begin
         mem_cnt_ff <= mem_cnt_in;
         cf_cnt_ff  <= cf_cnt_in;
         for (int i = 0; i < NUM_UNIT_CLASSES; i++) begin
            used_ff[i] <= used_in[i];
            if ((item_ff.operation == fpbd_pkg::OP_LOAD) && idx_valid
                && (item_ff.class_index == 4'(i))) begin
               mask_ff[i]  <= item_ff.class_mask[NUM_OP_TYPES_P-1:0];
               limit_ff[i] <= item_ff.class_limit;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
